### design/topk_inner_product_search_defines.svh
// assertion macros used by the top-level design file
`ifndef TOPK_INNER_PRODUCT_SEARCH_DEFINES_SVH
`define TOPK_INNER_PRODUCT_SEARCH_DEFINES_SVH
`ifndef SYNTHESIS
`define TIPS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TIPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TIPS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define TIPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### design/tips_pkg.sv
`default_nettype none
package tips_pkg;
  localparam int ScoreW = 38;
  localparam int IdW    = 10;
  localparam int KW     = 5;
  localparam int DimW   = 7;

  typedef enum logic [0:0] {
    CFG_DIMENSION = 1'b0,
    CFG_TOP_K     = 1'b1
  } cfg_idx_t;

  // control handed to every cell of the ranking chain
  typedef struct packed {
    logic clear;
    logic offer;
  } chain_ctl_t;
endpackage
`default_nettype wire

### design/topk_inner_product_search.sv
`default_nettype none
// channel | dir | contents
// in      | in  | tdata = value[15:0]; tuser = cmd
// out     | out | tdata = match_id[9:0], score[47:10]; tuser = found, last
// cfg     | in  | index 0 dimension, 1 top_k
// store elements and query elements that do not close a vector are accepted
// only while idle. a closing query element starts a scan over every stored
// vector and each element of the dimension (one MAC per cycle, one memory
// read port), ranks each vector after its scan, then sends the results.
// reset is synchronous; out_tvalid holds against out_tready stalls.
module topk_inner_product_search #(
  parameter int MAX_DIM     = 64,
  parameter int MAX_VECTORS = 1024,
  parameter int MAX_K       = 16,
  parameter int ELEM_WIDTH  = 16
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // value
  input  wire logic        in_tuser,   // cmd
  output logic             out_tvalid,
  input  wire              out_tready,
  output logic [47:0]      out_tdata,  // match_id, score
  output logic [1:0]       out_tuser,  // found, last
  input  wire              cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_wdata
);
  import tips_pkg::*;
  `include "topk_inner_product_search_defines.svh"

  localparam int DW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int VW  = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
  localparam int CW  = $clog2(MAX_VECTORS + 1);
  localparam int KCW = $clog2(MAX_K + 1);
  localparam int AW  = VW + DW;

  typedef enum logic [2:0] {S_IDLE, S_MAC, S_LAST, S_OFFER, S_OUT} state_t;

  logic [DimW-1:0] dim_r;
  logic [KW-1:0]   k_r;
  logic [CW-1:0]   count_r;
  logic [DW:0]     add_pos_r, q_pos_r, e_r;
  logic [VW-1:0]   vid_r;
  logic [KCW-1:0]  oidx_r, nres_r;
  state_t          state_r;

  logic signed [ELEM_WIDTH-1:0] store_mem [0:(1<<AW)-1];
  logic signed [ELEM_WIDTH-1:0] query_mem [0:(1<<DW)-1];
  logic signed [ELEM_WIDTH-1:0] s_rd_r, q_rd_r;
  logic signed [ELEM_WIDTH-1:0] in_val;

  logic [DW:0] eff_dim;
  logic [KCW-1:0] eff_k;
  logic in_acc, do_store, q_close, mac_en, mac_start_r, mac_en_r;
  logic signed [ScoreW-1:0] acc;

  assign in_val = ELEM_WIDTH'($signed(in_tdata));

  always_comb begin
    if (dim_r == '0) eff_dim = (DW+1)'(1);
    else if (32'(dim_r) > MAX_DIM) eff_dim = (DW+1)'(MAX_DIM);
    else eff_dim = (DW+1)'(dim_r);
    if (k_r == '0) eff_k = KCW'(1);
    else if (32'(k_r) > MAX_K) eff_k = KCW'(MAX_K);
    else eff_k = KCW'(k_r);
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign do_store  = in_acc && !in_tuser && (32'(count_r) < MAX_VECTORS);
  assign q_close   = in_acc && in_tuser && ((q_pos_r + 1'b1) >= eff_dim);
  assign mac_en    = (state_r == S_MAC);

  // store and query memories, registered reads
  always_ff @(posedge clk) begin
    if (do_store) store_mem[{count_r[VW-1:0], add_pos_r[DW-1:0]}] <= in_val;
    if (in_acc && in_tuser) query_mem[q_pos_r[DW-1:0]] <= in_val;
    s_rd_r <= store_mem[{vid_r, e_r[DW-1:0]}];
    q_rd_r <= query_mem[e_r[DW-1:0]];
  end

  tips_mac #(.EW(ELEM_WIDTH)) u_mac (
    .clk(clk), .start(mac_start_r), .en(mac_en_r),
    .a(s_rd_r), .b(q_rd_r), .acc(acc)
  );

  // ranking chain
  chain_ctl_t ctl;
  logic [MAX_K:0] beaten_w;
  logic [MAX_K:0] valid_w;
  logic [IdW-1:0] id_w [0:MAX_K];
  logic signed [ScoreW-1:0] score_w [0:MAX_K];
  logic [MAX_K-1:0] bt;
  logic [MAX_K-1:0] kmask;

  assign ctl.clear = q_close;
  assign ctl.offer = (state_r == S_OFFER);
  assign beaten_w[0] = 1'b0;
  assign valid_w[0]  = 1'b0;
  assign id_w[0]     = '0;
  assign score_w[0]  = '0;

  genvar g;
  generate
    for (g = 0; g < MAX_K; g++) begin : g_cell
      chain_ctl_t cc;
      assign kmask[g] = (32'(g) < 32'(eff_k));
      assign cc.clear = ctl.clear;
      assign cc.offer = ctl.offer && kmask[g];
      tips_cell #(.IDW(IdW)) u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(cc),
        .cand_id(IdW'(vid_r)), .cand_score(acc),
        .up_beaten(beaten_w[g]), .up_valid(valid_w[g]),
        .up_id(id_w[g]), .up_score(score_w[g]),
        .beaten(bt[g]), .valid_o(valid_w[g+1]),
        .id_o(id_w[g+1]), .score_o(score_w[g+1])
      );
      assign beaten_w[g+1] = bt[g];
    end
  endgenerate

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; dim_r <= DimW'(1); k_r <= KW'(1);
      count_r <= '0; add_pos_r <= '0; q_pos_r <= '0;
      e_r <= '0; vid_r <= '0; oidx_r <= '0; nres_r <= '0;
      mac_en_r <= 1'b0; mac_start_r <= 1'b0;
    end else begin
      mac_en_r    <= mac_en;
      mac_start_r <= mac_en && (e_r == '0);
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_DIMENSION: begin
            dim_r <= cfg_wdata; count_r <= '0;
            add_pos_r <= '0; q_pos_r <= '0;
          end
          CFG_TOP_K: k_r <= cfg_wdata[KW-1:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (do_store) begin
            if ((add_pos_r + 1'b1) >= eff_dim) begin
              add_pos_r <= '0; count_r <= count_r + 1'b1;
            end else add_pos_r <= add_pos_r + 1'b1;
          end
          if (in_acc && in_tuser) begin
            if (q_close) begin
              q_pos_r <= '0; vid_r <= '0; e_r <= '0; oidx_r <= '0;
              if (count_r == '0) begin
                nres_r <= '0; state_r <= S_OUT;
              end else begin
                nres_r <= (32'(count_r) < 32'(eff_k)) ? KCW'(count_r) : eff_k;
                state_r <= S_MAC;
              end
            end else q_pos_r <= q_pos_r + 1'b1;
          end
        end
        S_MAC: begin
          if ((e_r + 1'b1) >= eff_dim) begin
            e_r <= '0; state_r <= S_LAST;
          end else e_r <= e_r + 1'b1;
        end
        S_LAST: state_r <= S_OFFER;
        S_OFFER: begin
          if (32'(vid_r) + 1 >= 32'(count_r)) state_r <= S_OUT;
          else begin
            vid_r <= vid_r + 1'b1; state_r <= S_MAC;
          end
        end
        S_OUT: begin
          if (out_tready) begin
            if (oidx_r + 1'b1 >= nres_r) state_r <= S_IDLE;
            else oidx_r <= oidx_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result mux over the chain slots
  logic [IdW-1:0] sel_id;
  logic signed [ScoreW-1:0] sel_score;
  always_comb begin
    sel_id = '0; sel_score = '0;
    for (int i = 0; i < MAX_K; i++) begin
      if (oidx_r == KCW'(i)) begin
        sel_id = id_w[i+1]; sel_score = score_w[i+1];
      end
    end
  end

  logic empty_q;
  assign empty_q    = (nres_r == '0);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = empty_q ? 48'd0 : {sel_score, sel_id};
  assign out_tuser  = {(empty_q || (oidx_r + 1'b1 >= nres_r)), !empty_q};

  `TIPS_ASSERT_IMPL(a_no_in_busy, clk, rst_n, state_r != S_IDLE, !in_tready,
    "input taken while busy")
  `TIPS_ASSERT_IMPL(a_count_cap, clk, rst_n, 1'b1, 32'(count_r) <= MAX_VECTORS,
    "store count above capacity")
  `TIPS_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(oidx_r), "result moved under stall")
endmodule
`default_nettype wire

### design/tips_cell.sv
`default_nettype none
// one slot of the sorted best list; entries shift down toward higher slots
module tips_cell #(
  parameter int IDW = 10
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire tips_pkg::chain_ctl_t        ctl,
  input  wire logic [IDW-1:0]              cand_id,
  input  wire logic signed [tips_pkg::ScoreW-1:0] cand_score,
  input  wire logic                        up_beaten,
  input  wire logic                        up_valid,
  input  wire logic [IDW-1:0]              up_id,
  input  wire logic signed [tips_pkg::ScoreW-1:0] up_score,
  output logic                             beaten,
  output logic                             valid_o,
  output logic [IDW-1:0]                   id_o,
  output logic signed [tips_pkg::ScoreW-1:0] score_o
);
  import tips_pkg::*;

  logic valid_r;
  logic [IDW-1:0] id_r;
  logic signed [ScoreW-1:0] score_r;

  // candidate beats this slot when slot is empty or ranks lower
  always_comb begin
    beaten = !valid_r || (cand_score > score_r) ||
             ((cand_score == score_r) && (cand_id < id_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      valid_r <= 1'b0;
    end else if (ctl.offer && beaten) begin
      if (up_beaten) begin
        valid_r <= up_valid;
        id_r    <= up_id;
        score_r <= up_score;
      end else begin
        valid_r <= 1'b1;
        id_r    <= cand_id;
        score_r <= cand_score;
      end
    end
  end

  assign valid_o = valid_r;
  assign id_o    = id_r;
  assign score_o = score_r;
endmodule
`default_nettype wire

### design/tips_mac.sv
`default_nettype none
// multiply-accumulate of one stored element against one query element
module tips_mac #(
  parameter int EW = 16
) (
  input  wire                    clk,
  input  wire                    start,
  input  wire                    en,
  input  wire logic signed [EW-1:0] a,
  input  wire logic signed [EW-1:0] b,
  output logic signed [tips_pkg::ScoreW-1:0] acc
);
  import tips_pkg::*;
  logic signed [2*EW-1:0] prod;
  logic signed [ScoreW-1:0] acc_r;
  assign prod = a * b;
  always_ff @(posedge clk) begin
    if (en) begin
      if (start) acc_r <= ScoreW'(prod);
      else acc_r <= acc_r + ScoreW'(prod);
    end
  end
  assign acc = acc_r;
endmodule
`default_nettype wire
